// ===== hw/rtl/smwt_pkg.sv =====
package smwt_pkg;

    // Field widths fixed by the sample and result formats
    localparam int STAMP_W    = 63;
    localparam int RATE_W     = 16;
    localparam int MOT_W      = 16;
    localparam int SQ_W       = 32;
    localparam int IMU_CNT_W  = 8;
    localparam int CAM_CNT_W  = 7;
    localparam int STAT_CNT_W = 8;
    localparam int GAP_W      = 32;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_IMU_GAP_NS       = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_GAP_NS       = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_ACTIVE_SQ    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_ACTIVE_LEVEL = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_MIN_FILL     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_MIN_ACTIVE   = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_MIN_FILL     = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CAM_MIN_ACTIVE   = 4'd7;

    // Register reset values
    localparam logic [GAP_W-1:0]     RST_IMU_GAP_NS       = 32'd20000000;
    localparam logic [GAP_W-1:0]     RST_CAM_GAP_NS       = 32'd40000000;
    localparam logic [SQ_W-1:0]      RST_IMU_ACTIVE_SQ    = 32'd262144;
    localparam logic [MOT_W-1:0]     RST_CAM_ACTIVE_LEVEL = 16'd8;
    localparam logic [IMU_CNT_W-1:0] RST_IMU_MIN_FILL     = 8'd40;
    localparam logic [IMU_CNT_W-1:0] RST_IMU_MIN_ACTIVE   = 8'd20;
    localparam logic [CAM_CNT_W-1:0] RST_CAM_MIN_FILL     = 7'd20;
    localparam logic [CAM_CNT_W-1:0] RST_CAM_MIN_ACTIVE   = 7'd10;

    // Sample source codes
    localparam logic ACT_IMU = 1'b0;
    localparam logic ACT_CAM = 1'b1;

    // Window status after an update
    typedef struct packed {
        logic [STAT_CNT_W-1:0] count;
        logic [STAT_CNT_W-1:0] active;
        logic                  cleared;
    } win_stat_t;

endpackage

// ===== hw/rtl/smwt_window.sv =====
module smwt_window
    import smwt_pkg::*;
#(
    parameter int DEPTH = 210
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [STAMP_W-1:0] stamp,
    input  logic [GAP_W-1:0]   gap,
    input  logic               act,
    output win_stat_t          stat
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [IW-1:0] LAST_C  = IW'(DEPTH - 1);

    logic [IW-1:0]      oldest_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      active_reg;
    logic [STAMP_W-1:0] last_stamp_reg;
    logic               oldest_flag_reg;
    logic               flag_mem [DEPTH];

    logic               gap_hit;
    logic [STAMP_W-1:0] jump;
    logic [IW-1:0]      o1;
    logic [CW-1:0]      c1;
    logic [CW-1:0]      a1;
    logic [IW-1:0]      oldest_next;
    logic [CW-1:0]      c2;
    logic [CW-1:0]      a2;
    logic [IW-1:0]      wr_slot;
    logic [CW:0]        slot_sum;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      active_next;

    assign jump = stamp - last_stamp_reg;

    always_comb
    begin
        gap_hit = (count_reg != '0) && (stamp > last_stamp_reg)
                  && (jump > {{(STAMP_W-GAP_W){1'b0}}, gap});
        o1 = gap_hit ? '0 : oldest_reg;
        c1 = gap_hit ? '0 : count_reg;
        a1 = gap_hit ? '0 : active_reg;
        slot_sum = {{(CW+1-IW){1'b0}}, o1} + {1'b0, c1};
        if (c1 >= DEPTH_C)
        begin
            // drop the oldest flag before the push
            a2 = (oldest_flag_reg && (a1 != '0)) ? a1 - 1'b1 : a1;
            oldest_next = (o1 == LAST_C) ? '0 : o1 + 1'b1;
            c2 = DEPTH_C - 1'b1;
            wr_slot = o1;
        end
        else
        begin
            a2 = a1;
            oldest_next = o1;
            c2 = c1;
            if (slot_sum >= {1'b0, DEPTH_C})
                wr_slot = IW'(slot_sum - {1'b0, DEPTH_C});
            else
                wr_slot = IW'(slot_sum);
        end
        count_next  = c2 + 1'b1;
        active_next = a2 + {{(CW-1){1'b0}}, act};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg     <= '0;
            count_reg      <= '0;
            active_reg     <= '0;
            last_stamp_reg <= '0;
        end
        else if (push)
        begin
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            active_reg     <= active_next;
            last_stamp_reg <= stamp;
        end
    end

    // Flag ring; keep the flag of the oldest slot prefetched, bypassing a write to it
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            flag_mem[wr_slot] <= act;
            oldest_flag_reg   <= (wr_slot == oldest_next) ? act : flag_mem[oldest_next];
        end
    end

    assign stat.count   = push ? STAT_CNT_W'(count_next)  : STAT_CNT_W'(count_reg);
    assign stat.active  = push ? STAT_CNT_W'(active_next) : STAT_CNT_W'(active_reg);
    assign stat.cleared = push && gap_hit;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("window fill above depth");

    a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= count_reg)
        else $error("active count above fill");

    a_clear_one: assert property (@(posedge clk) disable iff (!rst_n)
        push && gap_hit |=> count_reg == CW'(1))
        else $error("gap clear did not leave a single sample");

    a_full_stays: assert property (@(posedge clk) disable iff (!rst_n)
        push && !gap_hit && (count_reg == DEPTH_C) |=> count_reg == DEPTH_C)
        else $error("full window lost fill on push");

endmodule

// ===== hw/rtl/sensor_motion_window_tracker_top.sv =====
// Sensor motion window tracker.
// Input channel (in_valid / in_ready): one request per sample. action selects
// IMU (rates used) or camera (cam_motion, cam_motion_known used); stamp_ns is
// the sample time in ns. Output channel (out_valid / out_ready): one result per
// request with both window fills, active counts, the gap-clear flag of the
// sample's own stream and readiness against the four minimums.
// Configuration: cfg_we with cfg_index / cfg_data writes one register per
// cycle; write only while no request is in flight. Unknown indexes are dropped.
// From input accept to out_valid: input register, then the squared-norm
// multipliers, activity decision and window update in one pass into the result
// register. Throughput: one request per cycle while the receiver does not stall,
// with the ring push/pop of each window done in that same pass.
// Reset clears all windows and pipeline valids and loads the default register
// values. When the receiver stalls, the result register holds and the input
// register fills; in_ready drops once both registers hold a request.
module sensor_motion_window_tracker_top
    import smwt_pkg::*;
#(
    parameter int IMU_DEPTH = 210,
    parameter int CAM_DEPTH = 105
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [STAMP_W-1:0]    stamp_ns,
    input  logic signed [RATE_W-1:0] rate_x,
    input  logic signed [RATE_W-1:0] rate_y,
    input  logic signed [RATE_W-1:0] rate_z,
    input  logic [MOT_W-1:0]      cam_motion,
    input  logic                  cam_motion_known,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [IMU_CNT_W-1:0]  imu_fill,
    output logic [IMU_CNT_W-1:0]  imu_active_count,
    output logic [CAM_CNT_W-1:0]  cam_fill,
    output logic [CAM_CNT_W-1:0]  cam_active_count,
    output logic                  gap_cleared,
    output logic                  ready_res
);

    // Configuration registers
    logic [GAP_W-1:0]     imu_gap_ns_reg;
    logic [GAP_W-1:0]     cam_gap_ns_reg;
    logic [SQ_W-1:0]      imu_active_sq_reg;
    logic [MOT_W-1:0]     cam_active_level_reg;
    logic [IMU_CNT_W-1:0] imu_min_fill_reg;
    logic [IMU_CNT_W-1:0] imu_min_active_reg;
    logic [CAM_CNT_W-1:0] cam_min_fill_reg;
    logic [CAM_CNT_W-1:0] cam_min_active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            imu_gap_ns_reg       <= RST_IMU_GAP_NS;
            cam_gap_ns_reg       <= RST_CAM_GAP_NS;
            imu_active_sq_reg    <= RST_IMU_ACTIVE_SQ;
            cam_active_level_reg <= RST_CAM_ACTIVE_LEVEL;
            imu_min_fill_reg     <= RST_IMU_MIN_FILL;
            imu_min_active_reg   <= RST_IMU_MIN_ACTIVE;
            cam_min_fill_reg     <= RST_CAM_MIN_FILL;
            cam_min_active_reg   <= RST_CAM_MIN_ACTIVE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMU_GAP_NS:       imu_gap_ns_reg       <= cfg_data;
                REG_CAM_GAP_NS:       cam_gap_ns_reg       <= cfg_data;
                REG_IMU_ACTIVE_SQ:    imu_active_sq_reg    <= cfg_data;
                REG_CAM_ACTIVE_LEVEL: cam_active_level_reg <= cfg_data[MOT_W-1:0];
                REG_IMU_MIN_FILL:     imu_min_fill_reg     <= cfg_data[IMU_CNT_W-1:0];
                REG_IMU_MIN_ACTIVE:   imu_min_active_reg   <= cfg_data[IMU_CNT_W-1:0];
                REG_CAM_MIN_FILL:     cam_min_fill_reg     <= cfg_data[CAM_CNT_W-1:0];
                REG_CAM_MIN_ACTIVE:   cam_min_active_reg   <= cfg_data[CAM_CNT_W-1:0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    // Pipeline flow control: a stage takes a request when empty or when it drains
    logic s1_valid_reg;
    logic res_valid_reg;
    logic res_ready;
    logic s1_ready;
    logic s1_adv;

    assign res_ready = !res_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || res_ready;
    assign in_ready  = s1_ready;
    assign s1_adv    = s1_valid_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (res_ready)
                res_valid_reg <= s1_valid_reg;
        end
    end

    // Stage 1: registered request
    logic                     s1_action_reg;
    logic [STAMP_W-1:0]       s1_stamp_reg;
    logic signed [RATE_W-1:0] s1_rate_x_reg;
    logic signed [RATE_W-1:0] s1_rate_y_reg;
    logic signed [RATE_W-1:0] s1_rate_z_reg;
    logic [MOT_W-1:0]         s1_motion_reg;
    logic                     s1_known_reg;

    always_ff @(posedge clk)
    begin
        if (in_valid && s1_ready)
        begin
            s1_action_reg <= action;
            s1_stamp_reg  <= stamp_ns;
            s1_rate_x_reg <= rate_x;
            s1_rate_y_reg <= rate_y;
            s1_rate_z_reg <= rate_z;
            s1_motion_reg <= cam_motion;
            s1_known_reg  <= cam_motion_known;
        end
    end

    // Activity decision: squared rate norm for IMU, motion level for camera
    logic signed [SQ_W-1:0] sq_x;
    logic signed [SQ_W-1:0] sq_y;
    logic signed [SQ_W-1:0] sq_z;
    logic [SQ_W-1:0]        sq_sum;
    logic                   s1_act;

    assign sq_x = s1_rate_x_reg * s1_rate_x_reg;
    assign sq_y = s1_rate_y_reg * s1_rate_y_reg;
    assign sq_z = s1_rate_z_reg * s1_rate_z_reg;
    // each square is at most 2^30, so the three-way sum fits 32 bits
    assign sq_sum = {1'b0, sq_x[SQ_W-2:0]} + {1'b0, sq_y[SQ_W-2:0]}
                  + {1'b0, sq_z[SQ_W-2:0]};

    always_comb
    begin
        if (s1_action_reg == ACT_IMU)
            s1_act = sq_sum > imu_active_sq_reg;
        else
            s1_act = !s1_known_reg || (s1_motion_reg > cam_active_level_reg);
    end

    // Window update: advance the stream that the request belongs to
    win_stat_t imu_stat;
    win_stat_t cam_stat;
    logic      imu_push;
    logic      cam_push;

    assign imu_push = s1_adv && (s1_action_reg == ACT_IMU);
    assign cam_push = s1_adv && (s1_action_reg == ACT_CAM);

    smwt_window #(
        .DEPTH (IMU_DEPTH)
    ) u_imu_win (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (imu_push),
        .stamp (s1_stamp_reg),
        .gap   (imu_gap_ns_reg),
        .act   (s1_act),
        .stat  (imu_stat)
    );

    smwt_window #(
        .DEPTH (CAM_DEPTH)
    ) u_cam_win (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cam_push),
        .stamp (s1_stamp_reg),
        .gap   (cam_gap_ns_reg),
        .act   (s1_act),
        .stat  (cam_stat)
    );

    logic ready_next;

    assign ready_next = (imu_stat.count  >= STAT_CNT_W'(imu_min_fill_reg))
                     && (imu_stat.active >= STAT_CNT_W'(imu_min_active_reg))
                     && (cam_stat.count  >= STAT_CNT_W'(cam_min_fill_reg))
                     && (cam_stat.active >= STAT_CNT_W'(cam_min_active_reg));

    // Result register: hold while the receiver stalls
    logic [IMU_CNT_W-1:0] imu_fill_reg;
    logic [IMU_CNT_W-1:0] imu_active_reg;
    logic [CAM_CNT_W-1:0] cam_fill_reg;
    logic [CAM_CNT_W-1:0] cam_active_reg;
    logic                 gap_cleared_reg;
    logic                 ready_res_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            imu_fill_reg    <= IMU_CNT_W'(imu_stat.count);
            imu_active_reg  <= IMU_CNT_W'(imu_stat.active);
            cam_fill_reg    <= CAM_CNT_W'(cam_stat.count);
            cam_active_reg  <= CAM_CNT_W'(cam_stat.active);
            gap_cleared_reg <= (s1_action_reg == ACT_IMU) ? imu_stat.cleared
                                                          : cam_stat.cleared;
            ready_res_reg   <= ready_next;
        end
    end

    assign out_valid        = res_valid_reg;
    assign imu_fill         = imu_fill_reg;
    assign imu_active_count = imu_active_reg;
    assign cam_fill         = cam_fill_reg;
    assign cam_active_count = cam_active_reg;
    assign gap_cleared      = gap_cleared_reg;
    assign ready_res        = ready_res_reg;

endmodule

// ===== bench/tb_sensor_motion_window_tracker_top.sv =====
`timescale 1ns / 100ps

module tb_sensor_motion_window_tracker_top;
    import smwt_pkg::*;

    localparam int IMU_DEPTH      = 210;
    localparam int CAM_DEPTH      = 105;
    localparam int IMU_STREAM     = 0;
    localparam int CAM_STREAM     = 1;
    // Cycles to let pass after the last result before touching registers
    localparam int SETTLE_CYCLES  = 8;
    // Long receiver hold-off that backs the pipeline up into the input
    localparam int HOLD_LEN       = 300;
    // Cycles without any handshake before the run is declared hung
    localparam int WATCHDOG_LIMIT = 4000;
    // First index past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd8;

    typedef struct packed {
        logic                     action;
        logic [STAMP_W-1:0]       stamp;
        logic signed [RATE_W-1:0] rx;
        logic signed [RATE_W-1:0] ry;
        logic signed [RATE_W-1:0] rz;
        logic [MOT_W-1:0]         motion;
        logic                     known;
    } sensor_sample_t;

    typedef struct packed {
        logic [IMU_CNT_W-1:0] imu_fill;
        logic [IMU_CNT_W-1:0] imu_act;
        logic [CAM_CNT_W-1:0] cam_fill;
        logic [CAM_CNT_W-1:0] cam_act;
        logic                 cleared;
        logic                 ready;
    } window_status_t;

    // ------------------------------------------------------------------
    // Block ports
    // ------------------------------------------------------------------
    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic                     action = 1'b0;
    logic [STAMP_W-1:0]       stamp_ns = '0;
    logic signed [RATE_W-1:0] rate_x = '0;
    logic signed [RATE_W-1:0] rate_y = '0;
    logic signed [RATE_W-1:0] rate_z = '0;
    logic [MOT_W-1:0]         cam_motion = '0;
    logic                     cam_motion_known = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [IMU_CNT_W-1:0]     imu_fill;
    logic [IMU_CNT_W-1:0]     imu_active_count;
    logic [CAM_CNT_W-1:0]     cam_fill;
    logic [CAM_CNT_W-1:0]     cam_active_count;
    logic                     gap_cleared;
    logic                     ready_res;

    sensor_motion_window_tracker_top #(
        .IMU_DEPTH (IMU_DEPTH),
        .CAM_DEPTH (CAM_DEPTH)
    ) DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .action           (action),
        .stamp_ns         (stamp_ns),
        .rate_x           (rate_x),
        .rate_y           (rate_y),
        .rate_z           (rate_z),
        .cam_motion       (cam_motion),
        .cam_motion_known (cam_motion_known),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .imu_fill         (imu_fill),
        .imu_active_count (imu_active_count),
        .cam_fill         (cam_fill),
        .cam_active_count (cam_active_count),
        .gap_cleared      (gap_cleared),
        .ready_res        (ready_res)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the registers, updated as each write is issued
    // ------------------------------------------------------------------
    logic [GAP_W-1:0]     imu_gap_lim      = RST_IMU_GAP_NS;
    logic [GAP_W-1:0]     cam_gap_lim      = RST_CAM_GAP_NS;
    logic [SQ_W-1:0]      imu_sq_lim       = RST_IMU_ACTIVE_SQ;
    logic [MOT_W-1:0]     cam_level_lim    = RST_CAM_ACTIVE_LEVEL;
    logic [IMU_CNT_W-1:0] imu_min_fill_lim = RST_IMU_MIN_FILL;
    logic [IMU_CNT_W-1:0] imu_min_act_lim  = RST_IMU_MIN_ACTIVE;
    logic [CAM_CNT_W-1:0] cam_min_fill_lim = RST_CAM_MIN_FILL;
    logic [CAM_CNT_W-1:0] cam_min_act_lim  = RST_CAM_MIN_ACTIVE;

    // ------------------------------------------------------------------
    // Window state of both streams, indexed by IMU_STREAM / CAM_STREAM
    // ------------------------------------------------------------------
    bit          win_flag   [2][256];
    int unsigned win_oldest [2] = '{0, 0};
    int unsigned win_count  [2] = '{0, 0};
    int unsigned win_active [2] = '{0, 0};
    logic [63:0] win_last   [2] = '{64'd0, 64'd0};
    int unsigned win_depth  [2] = '{IMU_DEPTH, CAM_DEPTH};

    sensor_sample_t pending_samples [$];
    window_status_t expected_status [$];
    sensor_sample_t offered;
    sensor_sample_t next_sample;

    // Per-stream stamp of the last generated sample
    logic [STAMP_W-1:0] gen_stamp [2] = '{'0, '0};

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_req_cnt = 0;
    int stall_served  = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;

    int mismatches    = 0;
    int imu_items     = 0;
    int cam_items     = 0;
    int clears_seen   = 0;
    int ready_seen    = 0;
    int imu_full_seen = 0;
    int cam_full_seen = 0;
    int setting_count = 1;

    // Push one flag into a stream window; return 1 when a gap emptied it first
    function automatic bit push_flag(int s, logic [63:0] stamp, logic [GAP_W-1:0] gap,
                                     bit act);
        bit cleared;
        cleared = 1'b0;
        // Only a forward jump past the limit on a non-empty window clears it
        if (win_count[s] > 0 && stamp > win_last[s] &&
            (stamp - win_last[s]) > {32'd0, gap}) begin
            win_oldest[s] = 0;
            win_count[s]  = 0;
            win_active[s] = 0;
            cleared       = 1'b1;
        end
        // Full window: drop the oldest flag before the push
        if (win_count[s] >= win_depth[s]) begin
            if (win_flag[s][win_oldest[s]] && win_active[s] > 0)
                win_active[s] = win_active[s] - 1;
            win_oldest[s] = (win_oldest[s] + 1) % win_depth[s];
            win_count[s]  = win_depth[s] - 1;
        end
        win_flag[s][(win_oldest[s] + win_count[s]) % win_depth[s]] = act;
        win_count[s] = win_count[s] + 1;
        if (act)
            win_active[s] = win_active[s] + 1;
        win_last[s] = stamp;
        return cleared;
    endfunction

    // Advance the windows by one accepted request and return the expected status
    function automatic window_status_t advance_windows(sensor_sample_t smp);
        window_status_t st;
        longint         sq;
        bit             act;
        bit             clr;
        if (smp.action == ACT_IMU) begin
            sq = longint'(smp.rx) * longint'(smp.rx) + longint'(smp.ry) * longint'(smp.ry)
               + longint'(smp.rz) * longint'(smp.rz);
            act = sq > longint'({32'd0, imu_sq_lim});
            clr = push_flag(IMU_STREAM, {1'b0, smp.stamp}, imu_gap_lim, act);
        end
        else begin
            // No frame match counts as motion
            act = !smp.known || (smp.motion > cam_level_lim);
            clr = push_flag(CAM_STREAM, {1'b0, smp.stamp}, cam_gap_lim, act);
        end
        st.imu_fill = IMU_CNT_W'(win_count[IMU_STREAM]);
        st.imu_act  = IMU_CNT_W'(win_active[IMU_STREAM]);
        st.cam_fill = CAM_CNT_W'(win_count[CAM_STREAM]);
        st.cam_act  = CAM_CNT_W'(win_active[CAM_STREAM]);
        st.cleared  = clr;
        st.ready    = win_count[IMU_STREAM] >= imu_min_fill_lim &&
                      win_count[CAM_STREAM] >= cam_min_fill_lim &&
                      win_active[IMU_STREAM] >= imu_min_act_lim &&
                      win_active[CAM_STREAM] >= cam_min_act_lim;
        return st;
    endfunction

    // Often near the default threshold, mostly full range, sometimes extreme
    function automatic logic signed [RATE_W-1:0] pick_rate();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 35) begin
            v = int'($urandom_range(0, 1400)) - 700;
            return RATE_W'(v);
        end
        if (r < 85)
            return RATE_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return -16'sd32768;
            1:       return 16'sd32767;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    // Cluster around the activity level so both outcomes and the tie show up
    function automatic logic [MOT_W-1:0] pick_motion();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return cam_level_lim + MOT_W'($urandom_range(0, 2)) - 16'd1;
        if (r < 60)
            return MOT_W'($urandom_range(0, 63));
        if (r < 90)
            return MOT_W'($urandom);
        return ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
    endfunction

    // Build one random sample: mostly steady forward time, some gaps and noise
    function automatic sensor_sample_t make_sample(int clear_pct, int noise_pct, int imu_pct);
        sensor_sample_t     smp;
        int                 s;
        int                 r;
        logic [63:0]        gap;
        logic [STAMP_W-1:0] prev;
        smp.action = ($urandom_range(0, 99) < imu_pct) ? ACT_IMU : ACT_CAM;
        s    = (smp.action == ACT_IMU) ? IMU_STREAM : CAM_STREAM;
        gap  = (s == IMU_STREAM) ? {32'd0, imu_gap_lim} : {32'd0, cam_gap_lim};
        prev = gen_stamp[s];
        r    = $urandom_range(0, 99);
        if (r < clear_pct)
            smp.stamp = prev + STAMP_W'(gap) + STAMP_W'($urandom_range(1, 1000));
        else if (r < clear_pct + noise_pct) begin
            case ($urandom_range(0, 3))
                0:       smp.stamp = prev;
                1, 2:    smp.stamp = prev - STAMP_W'($urandom_range(1, 100000));
                default: smp.stamp = (clear_pct > 0) ? STAMP_W'({$urandom, $urandom}) : prev;
            endcase
        end
        else if (r < clear_pct + noise_pct + 3)
            smp.stamp = prev + STAMP_W'(gap);
        else
            smp.stamp = prev + STAMP_W'({32'd0, $urandom} % (gap + 64'd1));
        gen_stamp[s] = smp.stamp;
        // Fill the unused fields too; the block must ignore them
        smp.rx     = pick_rate();
        smp.ry     = pick_rate();
        smp.rz     = pick_rate();
        smp.motion = pick_motion();
        smp.known  = ($urandom_range(0, 99) >= 12);
        return smp;
    endfunction

    // Queue a hand-built request and keep the generator's time base in step
    task automatic queue_directed(logic act, logic [STAMP_W-1:0] stamp,
                                  logic signed [RATE_W-1:0] rx, logic signed [RATE_W-1:0] ry,
                                  logic signed [RATE_W-1:0] rz, logic [MOT_W-1:0] mot,
                                  logic known);
        sensor_sample_t smp;
        smp = '{act, stamp, rx, ry, rz, mot, known};
        gen_stamp[(act == ACT_IMU) ? IMU_STREAM : CAM_STREAM] = stamp;
        pending_samples.insert(pending_samples.size(), smp);
    endtask

    // Issue one register write and mirror it, truncated to the register width
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_IMU_GAP_NS:       imu_gap_lim      = data;
            REG_CAM_GAP_NS:       cam_gap_lim      = data;
            REG_IMU_ACTIVE_SQ:    imu_sq_lim       = data;
            REG_CAM_ACTIVE_LEVEL: cam_level_lim    = data[MOT_W-1:0];
            REG_IMU_MIN_FILL:     imu_min_fill_lim = data[IMU_CNT_W-1:0];
            REG_IMU_MIN_ACTIVE:   imu_min_act_lim  = data[IMU_CNT_W-1:0];
            REG_CAM_MIN_FILL:     cam_min_fill_lim = data[CAM_CNT_W-1:0];
            REG_CAM_MIN_ACTIVE:   cam_min_act_lim  = data[CAM_CNT_W-1:0];
            default: ;
        endcase
    endtask

    // Write all eight registers, plus one write past the list that must be dropped
    task automatic write_all(logic [31:0] igap, logic [31:0] cgap, logic [31:0] isq,
                             logic [31:0] clvl, logic [31:0] ifill, logic [31:0] iact,
                             logic [31:0] cfill, logic [31:0] cact);
        write_reg(REG_IMU_GAP_NS, igap);
        write_reg(REG_CAM_GAP_NS, cgap);
        write_reg(REG_IMU_ACTIVE_SQ, isq);
        write_reg(REG_CAM_ACTIVE_LEVEL, clvl);
        write_reg(REG_IMU_MIN_FILL, ifill);
        write_reg(REG_IMU_MIN_ACTIVE, iact);
        write_reg(REG_CAM_MIN_FILL, cfill);
        write_reg(REG_CAM_MIN_ACTIVE, cact);
        write_reg(REG_FIRST_UNUSED + CFG_IDX_W'($urandom_range(0, 7)), $urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        setting_count++;
        @(negedge clk);
    endtask

    // Wait until every request has gone through and its result is checked
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_samples.size() != 0 || in_valid || expected_status.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random(int n, int clear_pct, int noise_pct, int imu_pct);
        repeat (n)
            pending_samples.insert(pending_samples.size(),
                                   make_sample(clear_pct, noise_pct, imu_pct));
    endtask

    task automatic check_field(string what, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, what, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Driver: offer the oldest pending request, hold it until accepted,
    // and predict its result at the accepting edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n)
            in_valid <= 1'b0;
        else begin
            if (in_valid && in_ready) begin
                expected_status.insert(expected_status.size(), advance_windows(offered));
                if (offered.action == ACT_IMU)
                    imu_items++;
                else
                    cam_items++;
            end
            // Advance only when nothing is held; a stalled request stays put
            if (!in_valid || in_ready) begin
                if (pending_samples.size() == 0 || $urandom_range(0, 99) < send_idle_pct)
                    in_valid <= 1'b0;
                else begin
                    next_sample = pending_samples[0];
                    pending_samples.delete(0);
                    offered          <= next_sample;
                    in_valid         <= 1'b1;
                    action           <= next_sample.action;
                    stamp_ns         <= next_sample.stamp;
                    rate_x           <= next_sample.rx;
                    rate_y           <= next_sample.ry;
                    rate_z           <= next_sample.rz;
                    cam_motion       <= next_sample.motion;
                    cam_motion_known <= next_sample.known;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random back-pressure, plus a long hold-off on request
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (stall_served != stall_req_cnt) begin
            stall_served <= stall_req_cnt;
            hold_left    <= HOLD_LEN;
            out_ready    <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (expected_status.size() == 0) begin
                $display("%0t unexpected result: no request outstanding", $time);
                mismatches++;
            end
            else begin
                check_field("imu_fill", expected_status[0].imu_fill, imu_fill);
                check_field("imu_active_count", expected_status[0].imu_act, imu_active_count);
                check_field("cam_fill", expected_status[0].cam_fill, cam_fill);
                check_field("cam_active_count", expected_status[0].cam_act, cam_active_count);
                check_field("gap_cleared", expected_status[0].cleared, gap_cleared);
                check_field("ready_res", expected_status[0].ready, ready_res);
                clears_seen   += expected_status[0].cleared;
                ready_seen    += expected_status[0].ready;
                imu_full_seen += (expected_status[0].imu_fill == IMU_DEPTH);
                cam_full_seen += (expected_status[0].cam_fill == CAM_DEPTH);
                expected_status.delete(0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no handshake happens for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Sender idles lightly, receiver heavily
        send_idle_pct = 22;
        recv_idle_pct = 82;

        // Directed part with reset register values.
        // Empty window push, then the largest squared norm.
        queue_directed(ACT_IMU, 63'd0, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
        queue_directed(ACT_IMU, 63'd1000, -16'sd32768, -16'sd32768, -16'sd32768,
                       16'hFFFF, 1'b1);
        // Equal stamp keeps the window; backward stamp keeps it too
        queue_directed(ACT_IMU, 63'd1000, 16'sd32767, 16'sd32767, 16'sd32767, 16'd0, 1'b0);
        // Norm exactly at the threshold is not active
        queue_directed(ACT_IMU, 63'd500, 16'sd512, 16'sd0, 16'sd0, 16'd0, 1'b0);
        // Jump equal to the gap limit keeps the window, one past clears it
        queue_directed(ACT_IMU, 63'd20000500, 16'sd513, 16'sd0, 16'sd0, 16'd0, 1'b0);
        queue_directed(ACT_IMU, 63'd40000501, 16'sd0, -16'sd513, 16'sd0, 16'd0, 1'b0);
        queue_directed(ACT_IMU, 63'd40000502, 16'sd0, 16'sd0, 16'sd32767, 16'd0, 1'b1);
        // Camera: unknown motion counts active, on the largest stamp
        queue_directed(ACT_CAM, {STAMP_W{1'b1}}, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b0);
        // Backward with motion exactly at the level, then just above it
        queue_directed(ACT_CAM, 63'd0, -16'sd1, -16'sd1, -16'sd1, 16'd8, 1'b1);
        queue_directed(ACT_CAM, 63'd40000000, 16'sd0, 16'sd0, 16'sd0, 16'd9, 1'b1);
        queue_directed(ACT_CAM, 63'd80000001, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b1);
        queue_directed(ACT_CAM, 63'd80000002, 16'sd0, 16'sd0, 16'sd0, 16'd0, 1'b1);
        queue_directed(ACT_CAM, 63'd80000003, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF, 1'b0);
        queue_directed(ACT_IMU, 63'd40000503, 16'sd32767, -16'sd32768, 16'sd1, 16'd0, 1'b0);
        queue_directed(ACT_IMU, {1'b0, {(STAMP_W-1){1'b1}}}, 16'sd0, 16'sd0, 16'sd0,
                       16'd0, 1'b0);
        queue_directed(ACT_IMU, 63'd40000504, -16'sd1, 16'sd1, 16'sd0, 16'd0, 1'b1);
        wait_drained();

        // Long steady stretch: fill both windows to capacity, tight readiness
        write_all(32'd5000000, 32'd10000000, 32'd262144, 32'd8,
                  32'd200, 32'd30, 32'd100, 32'd15);
        run_random(800, 0, 4, 62);
        wait_drained();

        // Sender idles heavily, receiver lightly
        send_idle_pct = 82;
        recv_idle_pct = 22;

        // All registers at zero: every forward jump clears, ready always holds
        write_all(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_random(180, 3, 8, 60);
        wait_drained();

        // All ones: thresholds and minimums that can never be met
        write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_random(180, 3, 8, 60);
        wait_drained();

        // Top of the stated ranges; only the all-minimum rates are active
        write_all(32'd1000, 32'd2000, 32'd3221225471, 32'd65535,
                  32'd210, 32'd210, 32'd105, 32'd105);
        run_random(180, 3, 8, 60);
        wait_drained();

        // Neither side idles from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Random values with junk in the unused upper bits
        write_all($urandom, $urandom, $urandom,
                  ($urandom << MOT_W) | $urandom_range(0, 300),
                  ($urandom << IMU_CNT_W) | $urandom_range(0, 210),
                  ($urandom << IMU_CNT_W) | $urandom_range(0, 210),
                  ($urandom << CAM_CNT_W) | $urandom_range(0, 105),
                  ($urandom << CAM_CNT_W) | $urandom_range(0, 105));
        run_random(180, 3, 8, 60);
        // Hold the receiver off while the sender keeps offering
        stall_req_cnt++;
        wait_drained();

        // Back to the reset values
        write_all(RST_IMU_GAP_NS, RST_CAM_GAP_NS, RST_IMU_ACTIVE_SQ, RST_CAM_ACTIVE_LEVEL,
                  RST_IMU_MIN_FILL, RST_IMU_MIN_ACTIVE, RST_CAM_MIN_FILL, RST_CAM_MIN_ACTIVE);
        run_random(180, 2, 6, 65);
        wait_drained();

        repeat (20) @(negedge clk);
        $display("Covered %0d samples (%0d IMU, %0d camera) over %0d register settings",
                 imu_items + cam_items, imu_items, cam_items, setting_count);
        $display("Results showed %0d gap clears, %0d ready, %0d full IMU, %0d full camera",
                 clears_seen, ready_seen, imu_full_seen, cam_full_seen);
        if (mismatches == 0 && expected_status.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/smwt_pkg.sv
hw/rtl/smwt_window.sv
hw/rtl/sensor_motion_window_tracker_top.sv
bench/tb_sensor_motion_window_tracker_top.sv
